[rtl/pr_pkg.sv]
// Shared constants, types and codes for the PageRank engine.
package pr_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 8192;

    localparam int ID_W       = 10;
    localparam int CMD_W      = 3;
    localparam int RANK_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int ITER_W     = 8;
    localparam int DAMP_W     = 16;
    localparam int QUO_W      = 43;

    localparam logic [ITER_W-1:0] ITER_RESET = 8'd10;
    localparam logic [DAMP_W-1:0] DAMP_RESET = 16'd55705;

    typedef logic [CMD_W-1:0]      cmd_t;
    typedef logic [ID_W-1:0]       vid_t;
    typedef logic [RANK_W-1:0]     rank_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cmd_t CMD_REG   = 3'd0;
    localparam cmd_t CMD_EDGE  = 3'd1;
    localparam cmd_t CMD_RUN   = 3'd2;
    localparam cmd_t CMD_READ  = 3'd3;
    localparam cmd_t CMD_CLEAR = 3'd4;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_MISSING = 2'd2;

    localparam cfg_idx_t CFG_ITER = 1'b0;
    localparam cfg_idx_t CFG_DAMP = 1'b1;

endpackage

[rtl/pr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pr_div.sv]
// Restoring divider producing one quotient bit per cycle.
module pr_div #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[rtl/pagerank_iterate_top.sv]
// Top level of the PageRank engine: command sequencer, vertex and edge memories, divider.
//
// A command is taken when start is high and busy is low; its single result appears on rank
// and status with done high for exactly one cycle, and the receiver cannot hold it off.
// Registering a vertex and reading a rank read the vertex entry and then respond. Adding an
// edge waits while the edge memory is scanned one entry at a time for a duplicate.
// After reset and on a clear command a clearing pass writes every vertex entry, one per
// cycle, and the block stays busy until it ends. A run initialises every vertex entry and
// then iterates; the divider, at one quotient bit per cycle, computes every rank share.
module pagerank_iterate_top #(
    parameter int MAX_VERTICES = pr_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = pr_pkg::MAX_EDGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pr_pkg::cmd_t      cmd,
    input  pr_pkg::vid_t      vertex,
    input  pr_pkg::vid_t      neighbor,
    input  logic              deleted,
    output logic              done,
    output pr_pkg::rank_t     rank,
    output pr_pkg::status_t   status,
    input  logic              cfg_write,
    input  pr_pkg::cfg_idx_t  cfg_index,
    input  pr_pkg::cfg_data_t cfg_data
);

    import pr_pkg::*;

    localparam int VDEPTH = (MAX_VERTICES > (1 << ID_W)) ? (1 << ID_W) : MAX_VERTICES;
    localparam int VAW    = $clog2(VDEPTH);
    localparam int ACW    = $clog2(VDEPTH + 1);
    localparam int DGW    = $clog2(MAX_EDGES + 1);
    localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DSW    = (DGW > ACW) ? DGW : ACW;
    localparam int EW     = 2 * ID_W;
    localparam int DEG_LO = 2 * RANK_W;
    localparam int DEL_B  = DEG_LO + DGW;
    localparam int PRS_B  = DEL_B + 1;
    localparam int VWW    = PRS_B + 1;

    localparam logic [4:0] S_CLR      = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_REG_WR   = 5'd2;
    localparam logic [4:0] S_EDGE_V   = 5'd3;
    localparam logic [4:0] S_EDGE_N   = 5'd4;
    localparam logic [4:0] S_DUP_RD   = 5'd5;
    localparam logic [4:0] S_DUP_CHK  = 5'd6;
    localparam logic [4:0] S_EDGE_ADD = 5'd7;
    localparam logic [4:0] S_READ     = 5'd8;
    localparam logic [4:0] S_R_DINIT  = 5'd9;
    localparam logic [4:0] S_R_DTELE  = 5'd10;
    localparam logic [4:0] S_I_RD     = 5'd11;
    localparam logic [4:0] S_I_WR     = 5'd12;
    localparam logic [4:0] S_A_RD     = 5'd13;
    localparam logic [4:0] S_A_WR     = 5'd14;
    localparam logic [4:0] S_A_DIV    = 5'd15;
    localparam logic [4:0] S_B_E      = 5'd16;
    localparam logic [4:0] S_B_S      = 5'd17;
    localparam logic [4:0] S_B_SCHK   = 5'd18;
    localparam logic [4:0] S_B_DIV    = 5'd19;
    localparam logic [4:0] S_B_T      = 5'd20;
    localparam logic [4:0] S_C_RD     = 5'd21;
    localparam logic [4:0] S_C_MUL    = 5'd22;
    localparam logic [4:0] S_C_WR     = 5'd23;

    logic [4:0]        state_reg, state_next;
    logic [VAW-1:0]    idx_reg, idx_next;
    logic [DGW-1:0]    e_reg, e_next;
    logic [ITER_W-1:0] it_reg, it_next;
    logic [DGW-1:0]    edge_cnt_reg, edge_cnt_next;
    logic [ACW-1:0]    act_reg, act_next;
    logic              clr_resp_reg, clr_resp_next;
    logic [ITER_W-1:0] iter_cfg_reg;
    logic [DAMP_W-1:0] damp_reg;
    logic              done_reg, done_next;
    rank_t             rank_reg, rank_next;
    status_t           status_reg, status_next;

    vid_t              vtx_reg, vtx_next;
    vid_t              nbr_reg, nbr_next;
    logic              del_reg, del_next;
    logic [VWW-1:0]    word_reg, word_next;
    logic [EW-1:0]     key_reg, key_next;
    rank_t             init_reg, init_next;
    logic [RANK_W:0]   tele_reg, tele_next;
    logic [RANK_W:0]   dn_reg, dn_next;
    logic [QUO_W-1:0]  dsum_reg, dsum_next;
    rank_t             q_reg, q_next;
    logic [48:0]       prod_reg, prod_next;

    logic              v_we;
    logic [VAW-1:0]    v_waddr, v_raddr;
    logic [VWW-1:0]    v_wdata, v_rdata;
    logic              e_we;
    logic [EAW-1:0]    e_waddr, e_raddr;
    logic [EW-1:0]     e_wdata, e_rdata;

    logic              div_start, div_done;
    logic [QUO_W-1:0]  div_num, div_quo;
    logic [DSW-1:0]    div_den;

    logic              resp;
    rank_t             resp_rank;
    status_t           resp_status;

    logic              rd_act, wd_act, rd_deg_zero, last_v, last_e;
    rank_t             rd_rold, rd_rnew, wd_rnew;
    logic [DGW-1:0]    rd_deg;
    logic [RANK_W:0]   gsum, mix;
    logic [RANK_W+1:0] usum;
    logic [48:0]       prod_mul;

    function automatic rank_t sat_quo(input logic [QUO_W-1:0] x);
        sat_quo = (x[QUO_W-1:RANK_W] != '0) ? '1 : x[RANK_W-1:0];
    endfunction

    pr_ram #(
        .WIDTH(VWW),
        .DEPTH(VDEPTH)
    ) u_vram (
        .clk  (clk),
        .we   (v_we),
        .waddr(v_waddr),
        .wdata(v_wdata),
        .raddr(v_raddr),
        .rdata(v_rdata)
    );

    pr_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_EDGES)
    ) u_eram (
        .clk  (clk),
        .we   (e_we),
        .waddr(e_waddr),
        .wdata(e_wdata),
        .raddr(e_raddr),
        .rdata(e_rdata)
    );

    pr_div #(
        .NUM_W(QUO_W),
        .DEN_W(DSW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (div_quo)
    );

    assign rd_rnew     = v_rdata[RANK_W-1:0];
    assign rd_rold     = v_rdata[DEG_LO-1:RANK_W];
    assign rd_deg      = v_rdata[DEL_B-1:DEG_LO];
    assign rd_act      = v_rdata[PRS_B] && !v_rdata[DEL_B];
    assign rd_deg_zero = (rd_deg == '0);
    assign wd_act      = word_reg[PRS_B] && !word_reg[DEL_B];
    assign wd_rnew     = word_reg[RANK_W-1:0];
    assign last_v      = (idx_reg == VAW'(VDEPTH - 1));
    assign last_e      = (DGW'(e_reg + 1'b1) == edge_cnt_reg);
    assign gsum        = {1'b0, rd_rnew} + {1'b0, q_reg};
    assign mix         = {1'b0, rd_rnew} + dn_reg;
    assign prod_mul    = mix * damp_reg;
    assign usum        = {1'b0, tele_reg} + {1'b0, prod_reg[48:16]};

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        e_next        = e_reg;
        it_next       = it_reg;
        edge_cnt_next = edge_cnt_reg;
        act_next      = act_reg;
        clr_resp_next = clr_resp_reg;
        vtx_next      = vtx_reg;
        nbr_next      = nbr_reg;
        del_next      = del_reg;
        word_next     = word_reg;
        key_next      = key_reg;
        init_next     = init_reg;
        tele_next     = tele_reg;
        dn_next       = dn_reg;
        dsum_next     = dsum_reg;
        q_next        = q_reg;
        prod_next     = prod_reg;
        v_we          = 1'b0;
        v_waddr       = idx_reg;
        v_wdata       = word_reg;
        v_raddr       = idx_reg;
        e_we          = 1'b0;
        e_waddr       = edge_cnt_reg[EAW-1:0];
        e_wdata       = {vtx_reg, nbr_reg};
        e_raddr       = e_reg[EAW-1:0];
        div_start     = 1'b0;
        div_num       = '0;
        div_den       = '0;
        resp          = 1'b0;
        resp_rank     = '0;
        resp_status   = ST_OK;

        case (state_reg)
            S_CLR:
            begin
                v_we     = 1'b1;
                v_wdata  = '0;
                idx_next = idx_reg + 1'b1;
                if (last_v)
                begin
                    idx_next      = '0;
                    state_next    = S_IDLE;
                    resp          = clr_resp_reg;
                    clr_resp_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                v_raddr = vertex[VAW-1:0];
                if (start)
                begin
                    vtx_next = vertex;
                    nbr_next = neighbor;
                    del_next = deleted;
                    e_next   = '0;
                    idx_next = '0;
                    case (cmd)
                        CMD_REG:
                        begin
                            if (32'(vertex) < MAX_VERTICES)
                            begin
                                state_next = S_REG_WR;
                            end
                            else
                            begin
                                resp = 1'b1;
                            end
                        end
                        CMD_EDGE:
                        begin
                            if ((32'(vertex) < MAX_VERTICES) && (32'(neighbor) < MAX_VERTICES))
                            begin
                                state_next = S_EDGE_V;
                            end
                            else
                            begin
                                resp        = 1'b1;
                                resp_status = ST_MISSING;
                            end
                        end
                        CMD_RUN:
                        begin
                            if (act_reg == '0)
                            begin
                                init_next  = '0;
                                state_next = S_I_RD;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                div_num    = QUO_W'(1) << RANK_W;
                                div_den    = DSW'(act_reg);
                                state_next = S_R_DINIT;
                            end
                        end
                        CMD_READ:
                        begin
                            if (32'(vertex) < MAX_VERTICES)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                resp = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            edge_cnt_next = '0;
                            act_next      = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_CLR;
                        end
                        default:
                        begin
                            resp = 1'b1;
                        end
                    endcase
                end
            end
            S_REG_WR:
            begin
                v_we       = 1'b1;
                v_waddr    = vtx_reg[VAW-1:0];
                v_wdata    = {1'b1, del_reg, v_rdata[DEL_B-1:0]};
                act_next   = act_reg - ACW'(rd_act) + ACW'(!del_reg);
                resp       = 1'b1;
                state_next = S_IDLE;
            end
            S_EDGE_V:
            begin
                word_next  = v_rdata;
                v_raddr    = nbr_reg[VAW-1:0];
                state_next = S_EDGE_N;
            end
            S_EDGE_N:
            begin
                if (!word_reg[PRS_B] || !v_rdata[PRS_B])
                begin
                    resp        = 1'b1;
                    resp_status = ST_MISSING;
                    state_next  = S_IDLE;
                end
                else if (edge_cnt_reg == '0)
                begin
                    state_next = S_EDGE_ADD;
                end
                else
                begin
                    state_next = S_DUP_RD;
                end
            end
            S_DUP_RD:
            begin
                state_next = S_DUP_CHK;
            end
            S_DUP_CHK:
            begin
                if (e_rdata == {vtx_reg, nbr_reg})
                begin
                    resp       = 1'b1;
                    state_next = S_IDLE;
                end
                else if (last_e)
                begin
                    state_next = S_EDGE_ADD;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_DUP_RD;
                end
            end
            S_EDGE_ADD:
            begin
                resp       = 1'b1;
                state_next = S_IDLE;
                if (edge_cnt_reg == DGW'(MAX_EDGES))
                begin
                    resp_status = ST_FULL;
                end
                else
                begin
                    e_we          = 1'b1;
                    v_we          = 1'b1;
                    v_waddr       = vtx_reg[VAW-1:0];
                    v_wdata       = {word_reg[PRS_B:DEL_B],
                                     word_reg[DEL_B-1:DEG_LO] + 1'b1,
                                     word_reg[DEG_LO-1:0]};
                    edge_cnt_next = edge_cnt_reg + 1'b1;
                end
            end
            S_READ:
            begin
                resp       = 1'b1;
                resp_rank  = rd_rold;
                state_next = S_IDLE;
            end
            S_R_DINIT:
            begin
                if (div_done)
                begin
                    init_next  = sat_quo(div_quo);
                    div_start  = 1'b1;
                    div_num    = QUO_W'({17'h10000 - {1'b0, damp_reg}, 16'h0000});
                    div_den    = DSW'(act_reg);
                    state_next = S_R_DTELE;
                end
            end
            S_R_DTELE:
            begin
                if (div_done)
                begin
                    tele_next  = div_quo[RANK_W:0];
                    state_next = S_I_RD;
                end
            end
            S_I_RD:
            begin
                state_next = S_I_WR;
            end
            S_I_WR:
            begin
                v_we    = 1'b1;
                v_wdata = {v_rdata[PRS_B:DEG_LO], (rd_act ? init_reg : RANK_W'(0)),
                           RANK_W'(0)};
                if (last_v)
                begin
                    idx_next = '0;
                    if ((act_reg == '0) || (iter_cfg_reg == '0))
                    begin
                        resp       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        it_next    = '0;
                        dsum_next  = '0;
                        state_next = S_A_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_I_RD;
                end
            end
            S_A_RD:
            begin
                state_next = S_A_WR;
            end
            S_A_WR:
            begin
                v_we      = 1'b1;
                v_wdata   = {v_rdata[PRS_B:RANK_W], RANK_W'(0)};
                dsum_next = dsum_reg + ((rd_act && rd_deg_zero) ? QUO_W'(rd_rold) : '0);
                if (last_v)
                begin
                    div_start  = 1'b1;
                    div_num    = dsum_next;
                    div_den    = DSW'(act_reg);
                    state_next = S_A_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_A_RD;
                end
            end
            S_A_DIV:
            begin
                if (div_done)
                begin
                    dn_next  = div_quo[RANK_W:0];
                    e_next   = '0;
                    idx_next = '0;
                    if (edge_cnt_reg == '0)
                    begin
                        state_next = S_C_RD;
                    end
                    else
                    begin
                        state_next = S_B_E;
                    end
                end
            end
            S_B_E:
            begin
                state_next = S_B_S;
            end
            S_B_S:
            begin
                key_next   = e_rdata;
                v_raddr    = e_rdata[ID_W+VAW-1:ID_W];
                state_next = S_B_SCHK;
            end
            S_B_SCHK:
            begin
                if (rd_act && !rd_deg_zero)
                begin
                    div_start  = 1'b1;
                    div_num    = QUO_W'(rd_rold);
                    div_den    = DSW'(rd_deg);
                    state_next = S_B_DIV;
                end
                else if (last_e)
                begin
                    state_next = S_C_RD;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_B_E;
                end
            end
            S_B_DIV:
            begin
                v_raddr = key_reg[VAW-1:0];
                if (div_done)
                begin
                    q_next     = div_quo[RANK_W-1:0];
                    state_next = S_B_T;
                end
            end
            S_B_T:
            begin
                if (rd_act)
                begin
                    v_we    = 1'b1;
                    v_waddr = key_reg[VAW-1:0];
                    v_wdata = {v_rdata[PRS_B:RANK_W],
                               (gsum[RANK_W] ? {RANK_W{1'b1}} : gsum[RANK_W-1:0])};
                end
                if (last_e)
                begin
                    state_next = S_C_RD;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_B_E;
                end
            end
            S_C_RD:
            begin
                state_next = S_C_MUL;
            end
            S_C_MUL:
            begin
                word_next  = v_rdata;
                prod_next  = prod_mul;
                state_next = S_C_WR;
            end
            S_C_WR:
            begin
                v_we    = 1'b1;
                v_wdata = {word_reg[PRS_B:DEG_LO],
                           (wd_act ? ((usum[RANK_W+1:RANK_W] != 2'b00) ? {RANK_W{1'b1}}
                                                                       : usum[RANK_W-1:0])
                                   : RANK_W'(0)),
                           wd_rnew};
                if (last_v)
                begin
                    idx_next = '0;
                    if (ITER_W'(it_reg + 1'b1) == iter_cfg_reg)
                    begin
                        resp       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        it_next    = it_reg + 1'b1;
                        dsum_next  = '0;
                        state_next = S_A_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_C_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        done_next   = resp;
        rank_next   = resp ? resp_rank : rank_reg;
        status_next = resp ? resp_status : status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            idx_reg      <= '0;
            e_reg        <= '0;
            it_reg       <= '0;
            edge_cnt_reg <= '0;
            act_reg      <= '0;
            clr_resp_reg <= 1'b0;
            done_reg     <= 1'b0;
            iter_cfg_reg <= ITER_RESET;
            damp_reg     <= DAMP_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            e_reg        <= e_next;
            it_reg       <= it_next;
            edge_cnt_reg <= edge_cnt_next;
            act_reg      <= act_next;
            clr_resp_reg <= clr_resp_next;
            done_reg     <= done_next;
            if (cfg_write && (cfg_index == CFG_ITER))
            begin
                iter_cfg_reg <= cfg_data[ITER_W-1:0];
            end
            if (cfg_write && (cfg_index == CFG_DAMP))
            begin
                damp_reg <= cfg_data[DAMP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg   <= rank_next;
        status_reg <= status_next;
        vtx_reg    <= vtx_next;
        nbr_reg    <= nbr_next;
        del_reg    <= del_next;
        word_reg   <= word_next;
        key_reg    <= key_next;
        init_reg   <= init_next;
        tele_reg   <= tele_next;
        dn_reg     <= dn_next;
        dsum_reg   <= dsum_next;
        q_reg      <= q_next;
        prod_reg   <= prod_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rank   = rank_reg;
    assign status = status_reg;

endmodule
